// ----- hw/rtl/svp_pkg.sv -----
`timescale 1ns / 1ps
package svp_pkg;
	localparam int MaxJoints = 64;
	localparam int JointIdxW = 6;
	localparam int PosW = 32;
	localparam int QuatW = 16;
	localparam int BiasW = 17;
	localparam int SumW = 48;
	localparam int RotW = 4 * QuatW;
	localparam int JointW = 3 * PosW + RotW;

	localparam logic [0:0] ModeJoint = 1'b0;
	localparam logic [0:0] ModeWeight = 1'b1;

	typedef struct packed {
		logic [0:0] mode;
		logic [5:0] joint_index;
		logic signed [31:0] vec_x;
		logic signed [31:0] vec_y;
		logic signed [31:0] vec_z;
		logic signed [15:0] quat_x;
		logic signed [15:0] quat_y;
		logic signed [15:0] quat_z;
		logic signed [15:0] quat_w;
		logic [16:0] bias_weight;
		logic [0:0] last_weight;
	} svp_in_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic [0:0] clipped;
	} svp_out_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic load;      // capture input item, issue table read
		logic rot1;      // first quaternion product
		logic rot2;      // second quaternion product
		logic accum;     // scale and accumulate
		logic emit;      // saturate sums into output register
	} svp_cmd_t;

	typedef struct packed {
		logic is_last;
		logic in_range;
	} svp_sts_t;
endpackage

// ----- hw/rtl/svp_if.sv -----
`timescale 1ns / 1ps
interface svp_in_if import svp_pkg::*; ();
	logic valid;
	logic ready;
	svp_in_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface svp_out_if import svp_pkg::*; ();
	logic valid;
	logic ready;
	svp_out_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/skinned_vertex_position.sv -----
`timescale 1ns / 1ps
// Channel   Dir  Payload
// in_ch     in   svp_in_t: joint write (mode 0) or one vertex weight (mode 1)
// out_ch    out  svp_out_t: skinned position and clip flag, one per last weight
//
// A joint write goes straight into the joint table. A weight passes through
// table read, first quaternion product, second product, scale and accumulate;
// a last weight adds a step to load the output register. Reset clears the
// controller, sums and output valid; the joint table is not cleared. A held
// output transfer stalls only the emit step of the next last weight.
module skinned_vertex_position import svp_pkg::*; (
	input logic clk,
	input logic arst_n,
	svp_in_if.sink in_ch,
	svp_out_if.source out_ch
);
	svp_cmd_t cmd;
	svp_sts_t sts;
	logic out_full;
	logic in_fire;

	// An input transfer happens when the controller is idle.
	assign in_fire = in_ch.valid && in_ch.ready;
	assign out_ch.valid = out_full;

	svp_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid),
		.in_mode(in_ch.data.mode), .in_ready(in_ch.ready),
		.out_full(out_full), .sts(sts), .cmd(cmd)
	);

	svp_dp u_dp (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .in_data(in_ch.data),
		.cmd(cmd), .sts(sts), .out_take(out_ch.ready), .out_full(out_full),
		.out_data(out_ch.data)
	);

	// Only one datapath step is commanded per cycle.
	a_onestep: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.rot1, cmd.rot2, cmd.accum, cmd.emit}))
		else $error("multiple steps");
	// A weight transfer always leads to the first product step.
	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> cmd.rot1) else $error("lost weight");
	// Emission never overwrites an untaken result.
	a_noover: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !out_full) else $error("overwrite");
endmodule

// ----- hw/rtl/svp_ram.sv -----
`timescale 1ns / 1ps
module svp_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(Depth)-1:0] waddr,
	input logic [Width-1:0] wdata,
	input logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- hw/rtl/svp_ctrl.sv -----
`timescale 1ns / 1ps
module svp_ctrl import svp_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic [0:0] in_mode,
	output logic in_ready,
	input logic out_full,
	input svp_sts_t sts,
	output svp_cmd_t cmd
);
	typedef enum logic [2:0] {S_IDLE, S_ROT1, S_ROT2, S_ACC, S_EMIT} state_t;
	state_t state_q;

	// Emission waits until the output register is free.
	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		cmd.load = in_valid && in_ready && (in_mode == ModeWeight);
		cmd.rot1 = (state_q == S_ROT1);
		cmd.rot2 = (state_q == S_ROT2);
		cmd.accum = (state_q == S_ACC);
		cmd.emit = (state_q == S_EMIT) && !out_full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: if (cmd.load) state_q <= S_ROT1;
				S_ROT1: state_q <= S_ROT2;
				S_ROT2: state_q <= S_ACC;
				S_ACC: state_q <= sts.is_last ? S_EMIT : S_IDLE;
				S_EMIT: if (!out_full) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ----- hw/rtl/svp_dp.sv -----
`timescale 1ns / 1ps
module svp_dp import svp_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_fire,
	input svp_in_t in_data,
	input svp_cmd_t cmd,
	output svp_sts_t sts,
	input logic out_take,
	output logic out_full,
	output svp_out_t out_data
);
	localparam int PW = 38;
	localparam int TW = PW + BiasW + 2;
	localparam logic signed [SumW-1:0] SumHi = {1'b0, {(SumW-1){1'b1}}};
	localparam logic signed [SumW-1:0] SumLo = {1'b1, {(SumW-1){1'b0}}};

	logic we;
	logic [JointW-1:0] wdata, rdata;
	logic [JointIdxW-1:0] widx;
	logic [JointIdxW-1:0] idx_q;
	logic [JointIdxW-1:0] raddr;
	logic signed [PosW-1:0] v_q [3];
	logic [BiasW-1:0] bias_q;
	logic last_q, inr_q;
	logic signed [PW-1:0] p_q [4];
	logic signed [PW-1:0] r_q [3];
	logic signed [SumW-1:0] sum_q [3];
	logic signed [QuatW-1:0] qx, qy, qz, qw;
	logic signed [PosW-1:0] jp [3];

	assign widx = in_data.joint_index;
	assign we = in_fire && (in_data.mode == ModeJoint) && (32'(widx) < MaxJoints);
	assign wdata = {in_data.vec_x, in_data.vec_y, in_data.vec_z,
		in_data.quat_w, in_data.quat_z, in_data.quat_y, in_data.quat_x};

	// The table keeps reading the captured joint until the weight is done.
	assign raddr = cmd.load ? widx : idx_q;

	svp_ram #(.Width(JointW), .Depth(MaxJoints)) u_tab (
		.clk(clk), .we(we), .waddr(widx), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	// Out-of-range joints read as zero.
	always_comb begin
		{jp[0], jp[1], jp[2], qw, qz, qy, qx} = inr_q ? rdata : '0;
	end

	assign sts.is_last = last_q;
	assign sts.in_range = inr_q;

	function automatic logic signed [PW-1:0] rnd14(input logic signed [PW+18:0] s);
		logic signed [PW+18:0] t;
		t = s + (PW+19)'(1 << 13);
		return PW'(t >>> 14);
	endfunction

	function automatic logic signed [SumW-1:0] sat48(input logic signed [SumW+1:0] s);
		if (s > (SumW+2)'(SumHi)) return SumHi;
		if (s < (SumW+2)'(SumLo)) return SumLo;
		return SumW'(s);
	endfunction

	logic signed [PW+18:0] pm [4];
	logic signed [PW+18:0] rm [3];
	logic signed [TW-1:0] tm [3];
	logic signed [SumW+1:0] ns [3];

	always_comb begin
		pm[0] = -(qx * v_q[0]) - (qy * v_q[1]) - (qz * v_q[2]);
		pm[1] = (qw * v_q[0]) + (qy * v_q[2]) - (qz * v_q[1]);
		pm[2] = (qw * v_q[1]) - (qx * v_q[2]) + (qz * v_q[0]);
		pm[3] = (qw * v_q[2]) + (qx * v_q[1]) - (qy * v_q[0]);
		rm[0] = -(p_q[0] * qx) + (p_q[1] * qw) - (p_q[2] * qz) + (p_q[3] * qy);
		rm[1] = -(p_q[0] * qy) + (p_q[1] * qz) + (p_q[2] * qw) - (p_q[3] * qx);
		rm[2] = -(p_q[0] * qz) - (p_q[1] * qy) + (p_q[2] * qx) + (p_q[3] * qw);
		for (int i = 0; i < 3; i++) begin
			tm[i] = (TW'(jp[i]) + TW'(r_q[i])) * $signed({1'b0, bias_q})
				+ TW'(1 << 15);
			ns[i] = (SumW+2)'(sum_q[i]) + (SumW+2)'(tm[i] >>> 16);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			v_q[0] <= in_data.vec_x;
			v_q[1] <= in_data.vec_y;
			v_q[2] <= in_data.vec_z;
			bias_q <= in_data.bias_weight;
			last_q <= in_data.last_weight;
			inr_q <= (32'(widx) < MaxJoints);
			idx_q <= widx;
		end
		if (cmd.rot1) begin
			for (int i = 0; i < 4; i++) p_q[i] <= rnd14(pm[i]);
		end
		if (cmd.rot2) begin
			for (int i = 0; i < 3; i++) r_q[i] <= rnd14(rm[i]);
		end
	end

	logic [2:0] clip;
	logic signed [PosW-1:0] o [3];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			clip[i] = 1'b0;
			o[i] = PosW'(sum_q[i]);
			if (sum_q[i] > SumW'(32'sh7fffffff)) begin
				clip[i] = 1'b1; o[i] = 32'sh7fffffff;
			end else if (sum_q[i] < -SumW'(32'sh7fffffff) - 1) begin
				clip[i] = 1'b1; o[i] = 32'sh80000000;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) sum_q[i] <= '0;
			out_full <= 1'b0;
		end else begin
			if (cmd.accum) begin
				for (int i = 0; i < 3; i++) sum_q[i] <= sat48(ns[i]);
			end
			if (cmd.emit) begin
				for (int i = 0; i < 3; i++) sum_q[i] <= '0;
			end
			if (cmd.emit) out_full <= 1'b1;
			else if (out_take) out_full <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_data <= '{o[0], o[1], o[2], |clip};
		end
	end
endmodule
